[hdl/segment_local_transform_top_macros.svh]
// assertion helpers shared by the rtl
`ifndef SEGMENT_LOCAL_TRANSFORM_TOP_MACROS_SVH
`define SEGMENT_LOCAL_TRANSFORM_TOP_MACROS_SVH

// next-cycle implication, checked outside reset
`define SLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slt check failed");

// next-cycle implication, checked during reset as well
`define SLT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("slt check failed");

`endif

[hdl/slt_pkg.sv]
`default_nettype none
package slt_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 16;
   localparam int LANES         = 4;
   localparam int XW            = FRAC_BITS + 3;
   localparam int ZW            = 34;
   localparam int PW            = 48;
   localparam int SIW           = 5;
   localparam int NPROD         = 9;

   // cordic start value, gain rounded to the fraction width
   localparam longint GAIN_Q30   = 64'd652032874;
   localparam longint GAIN_START =
      (GAIN_Q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

   // register indexes
   localparam logic [2:0] CSR_JOINT_ENABLE = 3'd0;
   localparam logic [2:0] CSR_BASE_SHIFT   = 3'd1;
   localparam logic [2:0] CSR_PIVOT_SHIFT  = 3'd2;
   localparam logic [2:0] CSR_FIXED_TURN   = 3'd3;
   localparam logic [2:0] CSR_FIXED_AXIS   = 3'd4;
   localparam logic [2:0] CSR_SCALE_XYZ    = 3'd5;

   localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sd2147483647);
   localparam logic signed [PW-1:0] SAT_MIN = PW'(-64'sd2147483648);

   typedef struct packed {
      logic [LANES-1:0][31:0] row;
      logic [LANES-1:0][XW-1:0] x;
      logic [LANES-1:0][XW-1:0] y;
      logic [LANES-1:0][ZW-1:0] z;
      logic [LANES-1:0][1:0] quad;
   } cell_type;

   typedef struct packed {
      logic [LANES-1:0][XW-1:0] c;
      logic [LANES-1:0][XW-1:0] s;
   } trig_type;

   typedef struct packed {
      logic [2:0]  joint_enable;
      logic [47:0] base_shift;
      logic [47:0] pivot_shift;
      logic [15:0] fixed_turn;
      logic [47:0] fixed_axis;
      logic [47:0] scale_xyz;
   } cfg_type;

   typedef struct packed {
      logic [3:0][31:0] r;
      logic f;
      logic [NPROD-1:0][PW-1:0] p;
      trig_type t;
   } row_type;

   // arctangent of 2^-i in 1/2^32 turn
   function automatic logic [ZW-1:0] atan_turn(input logic [SIW-1:0] i);
      logic [ZW-1:0] v;
      unique case (i)
         5'd0:  v = ZW'(536870912);
         5'd1:  v = ZW'(316933406);
         5'd2:  v = ZW'(167458907);
         5'd3:  v = ZW'(85004756);
         5'd4:  v = ZW'(42667331);
         5'd5:  v = ZW'(21354465);
         5'd6:  v = ZW'(10679838);
         5'd7:  v = ZW'(5340245);
         5'd8:  v = ZW'(2670163);
         5'd9:  v = ZW'(1335087);
         5'd10: v = ZW'(667544);
         5'd11: v = ZW'(333772);
         5'd12: v = ZW'(166886);
         5'd13: v = ZW'(83443);
         5'd14: v = ZW'(41722);
         5'd15: v = ZW'(20861);
         5'd16: v = ZW'(10430);
         5'd17: v = ZW'(5215);
         5'd18: v = ZW'(2608);
         5'd19: v = ZW'(1304);
         5'd20: v = ZW'(652);
         5'd21: v = ZW'(326);
         5'd22: v = ZW'(163);
         5'd23: v = ZW'(81);
         default: v = '0;
      endcase
      return v;
   endfunction

   // product with round half up, then floor shift by n
   function automatic logic signed [PW-1:0] mulq(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input int n);
      logic signed [63:0] prod;
      prod = 64'(a) * 64'(b);
      prod = prod + (64'sd1 <<< (n - 1));
      return PW'(prod >>> n);
   endfunction

   function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
      logic [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'h7fff_ffff;
      end else if (v < SAT_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic ovf32(input logic signed [PW-1:0] v);
      return (v > SAT_MAX) || (v < SAT_MIN);
   endfunction

   function automatic logic signed [PW-1:0] sx(input logic [31:0] v);
      return PW'($signed(v));
   endfunction

   // signed q8.8 lane of a packed x,y,z word, x in the top lane
   function automatic logic signed [31:0] q8(input logic [47:0] w, input int lane);
      return 32'($signed(w[32 - 16 * lane +: 16]));
   endfunction

endpackage
`default_nettype wire

[hdl/slt_cordic_cell.sv]
`default_nettype none
module slt_cordic_cell import slt_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic [SIW-1:0] stage_idx,
   input  wire logic           in_valid,
   input  wire cell_type       in_data,
   output logic                out_valid,
   output cell_type            out_data
);

   logic          valid_ff;
   cell_type      data_ff;
   cell_type      data_in;
   logic [ZW-1:0] atan_val;

   assign atan_val = atan_turn(stage_idx);

   // one rotation step on every lane
   always_comb begin
      data_in = in_data;
      for (int l = 0; l < LANES; l++) begin
         if (!in_data.z[l][ZW-1]) begin
            data_in.x[l] = in_data.x[l] - XW'($signed(in_data.y[l]) >>> stage_idx);
            data_in.y[l] = in_data.y[l] + XW'($signed(in_data.x[l]) >>> stage_idx);
            data_in.z[l] = in_data.z[l] - atan_val;
         end else begin
            data_in.x[l] = in_data.x[l] + XW'($signed(in_data.y[l]) >>> stage_idx);
            data_in.y[l] = in_data.y[l] - XW'($signed(in_data.x[l]) >>> stage_idx);
            data_in.z[l] = in_data.z[l] + atan_val;
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

[hdl/slt_row_path.sv]
`default_nettype none
module slt_row_path import slt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire logic [3:0][31:0] in_row,
   input  wire trig_type         in_trig,
   input  wire cfg_type          cfg,
   output logic                  out_valid,
   output logic [3:0][31:0]      out_row,
   output logic                  out_sat
);

   localparam int ST_YM = 0;
   localparam int ST_YA = 1;
   localparam int ST_BM = 2;
   localparam int ST_BA = 3;
   localparam int ST_PM = 4;
   localparam int ST_PA = 5;
   localparam int ST_VM = 6;
   localparam int ST_VA = 7;
   localparam int ST_HM = 8;
   localparam int ST_HA = 9;
   localparam int ST_DM = 10;
   localparam int ST_DA = 11;
   localparam int ST_EM = 12;
   localparam int ST_EA = 13;
   localparam int ST_XM = 14;
   localparam int ST_XA = 15;
   localparam int ST_WM = 16;
   localparam int ST_WA = 17;
   localparam int ST_RM = 18;
   localparam int ST_RA = 19;
   localparam int ST_SM = 20;
   localparam int ST_SA = 21;
   localparam int NST   = 22;

   localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] HALF_Q = 32'sd128;

   function automatic logic signed [31:0] cw(input logic [XW-1:0] v);
      return 32'($signed(v));
   endfunction

   // one step of the row transform; even steps multiply, odd steps add and clip
   function automatic row_type row_step(input int k, input row_type a, input cfg_type c);
      row_type o;
      logic signed [PW-1:0] s0, s1, s2, s3;
      logic signed [31:0] tc, ts;
      o  = a;
      s0 = '0;
      s1 = '0;
      s2 = '0;
      s3 = '0;
      tc = '0;
      ts = '0;
      unique case (k)
         ST_YM: begin
            tc = cw(a.t.c[0]);
            ts = cw(a.t.s[0]);
            o.p[0] = mulq(a.r[0], tc, FRAC_BITS);
            o.p[1] = mulq(a.r[2], ts, FRAC_BITS);
            o.p[2] = mulq(a.r[0], ts, FRAC_BITS);
            o.p[3] = mulq(a.r[2], tc, FRAC_BITS);
         end
         ST_YA: begin
            if (c.joint_enable[0]) begin
               s0 = $signed(a.p[0]) - $signed(a.p[1]);
               s1 = $signed(a.p[2]) + $signed(a.p[3]);
               o.r[0] = sat32(s0);
               o.r[2] = sat32(s1);
               o.f = a.f | ovf32(s0) | ovf32(s1);
            end
         end
         ST_BM, ST_VM: begin
            o.p[0] = mulq(a.r[0], q8(k == ST_BM ? c.base_shift : c.pivot_shift, 0), 8);
            o.p[1] = mulq(a.r[1], q8(k == ST_BM ? c.base_shift : c.pivot_shift, 1), 8);
            o.p[2] = mulq(a.r[2], q8(k == ST_BM ? c.base_shift : c.pivot_shift, 2), 8);
         end
         ST_BA, ST_VA: begin
            s0 = sx(a.r[3]) + $signed(a.p[0]) + $signed(a.p[1]) + $signed(a.p[2]);
            o.r[3] = sat32(s0);
            o.f = a.f | ovf32(s0);
         end
         ST_PM, ST_DM: begin
            tc = cw(a.t.c[k == ST_PM ? 1 : 2]);
            ts = cw(a.t.s[k == ST_PM ? 1 : 2]);
            o.p[0] = mulq(a.r[1], tc, FRAC_BITS);
            o.p[1] = mulq(a.r[2], ts, FRAC_BITS);
            o.p[2] = mulq(a.r[2], tc, FRAC_BITS);
            o.p[3] = mulq(a.r[1], ts, FRAC_BITS);
         end
         ST_PA, ST_DA: begin
            if ((k == ST_PA && c.joint_enable[1]) || (k == ST_DA && c.joint_enable[2])) begin
               s0 = $signed(a.p[0]) + $signed(a.p[1]);
               s1 = $signed(a.p[2]) - $signed(a.p[3]);
               o.r[1] = sat32(s0);
               o.r[2] = sat32(s1);
               o.f = a.f | ovf32(s0) | ovf32(s1);
            end
         end
         ST_HM: begin
            o.p[1] = mulq(a.r[1], -HALF_Q, 8);
         end
         ST_EM: begin
            o.p[1] = mulq(a.r[1], HALF_Q, 8);
         end
         ST_HA, ST_EA: begin
            if (c.joint_enable[2]) begin
               s0 = sx(a.r[3]) + $signed(a.p[1]);
               o.r[3] = sat32(s0);
               o.f = a.f | ovf32(s0);
            end
         end
         ST_XM: begin
            o.p[0] = mulq(a.r[0], q8(c.fixed_axis, 0), 8);
            o.p[1] = mulq(a.r[1], q8(c.fixed_axis, 1), 8);
            o.p[2] = mulq(a.r[2], q8(c.fixed_axis, 2), 8);
            o.p[3] = mulq(a.r[1], q8(c.fixed_axis, 2), 8);
            o.p[4] = mulq(a.r[2], q8(c.fixed_axis, 1), 8);
            o.p[5] = mulq(a.r[2], q8(c.fixed_axis, 0), 8);
            o.p[6] = mulq(a.r[0], q8(c.fixed_axis, 2), 8);
            o.p[7] = mulq(a.r[0], q8(c.fixed_axis, 1), 8);
            o.p[8] = mulq(a.r[1], q8(c.fixed_axis, 0), 8);
         end
         ST_XA: begin
            // dot product in p0, cross terms in p1..p3
            s0 = $signed(a.p[0]) + $signed(a.p[1]) + $signed(a.p[2]);
            s1 = $signed(a.p[3]) - $signed(a.p[4]);
            s2 = $signed(a.p[5]) - $signed(a.p[6]);
            s3 = $signed(a.p[7]) - $signed(a.p[8]);
            o.p[0] = sx(sat32(s0));
            o.p[1] = sx(sat32(s1));
            o.p[2] = sx(sat32(s2));
            o.p[3] = sx(sat32(s3));
            if (c.fixed_turn != '0) begin
               o.f = a.f | ovf32(s0) | ovf32(s1) | ovf32(s2) | ovf32(s3);
            end
         end
         ST_WM: begin
            tc = cw(a.t.c[3]);
            o.p[4] = mulq(a.p[0][31:0], ONE_Q - tc, FRAC_BITS);
         end
         ST_WA: begin
            o.p[4] = sx(sat32($signed(a.p[4])));
            if (c.fixed_turn != '0) begin
               o.f = a.f | ovf32($signed(a.p[4]));
            end
         end
         ST_RM: begin
            tc = cw(a.t.c[3]);
            ts = cw(a.t.s[3]);
            for (int j = 0; j < 3; j++) begin
               o.p[3*j]   = mulq(a.r[j], tc, FRAC_BITS);
               o.p[3*j+1] = mulq(a.p[4][31:0], q8(c.fixed_axis, j), 8);
               o.p[3*j+2] = mulq(a.p[j+1][31:0], ts, FRAC_BITS);
            end
         end
         ST_RA: begin
            if (c.fixed_turn != '0) begin
               for (int j = 0; j < 3; j++) begin
                  s0 = $signed(a.p[3*j]) + $signed(a.p[3*j+1]) + $signed(a.p[3*j+2]);
                  o.r[j] = sat32(s0);
                  o.f = o.f | ovf32(s0);
               end
            end
         end
         ST_SM: begin
            for (int j = 0; j < 3; j++) begin
               o.p[j] = mulq(a.r[j], q8(c.scale_xyz, j), 8);
            end
         end
         ST_SA: begin
            for (int j = 0; j < 3; j++) begin
               o.r[j] = sat32($signed(a.p[j]));
               o.f = o.f | ovf32($signed(a.p[j]));
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   row_type    entry;
   row_type    stage_ff [NST];
   logic [NST-1:0] valid_ff;
   logic       out_valid_ff;
   logic [3:0][31:0] out_row_ff;
   logic       out_sat_ff;

   always_comb begin
      entry   = '0;
      entry.r = in_row;
      entry.t = in_trig;
   end

   // chain of transform steps
   for (genvar k = 0; k < NST; k++) begin : g_step
      row_type cur;
      row_type nxt;
      logic    cur_v;
      if (k == 0) begin : g_first
         assign cur   = entry;
         assign cur_v = in_valid;
      end else begin : g_rest
         assign cur   = stage_ff[k-1];
         assign cur_v = valid_ff[k-1];
      end
      assign nxt = row_step(k, cur, cfg);
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= cur_v;
         end
         if (advance) begin
            stage_ff[k] <= nxt;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[NST-1];
      end
      if (advance) begin
         out_row_ff <= stage_ff[NST-1].r;
         out_sat_ff <= stage_ff[NST-1].f;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_row   = out_row_ff;
   assign out_sat   = out_sat_ff;

endmodule
`default_nettype wire

[hdl/segment_local_transform_top.sv]
`default_nettype none
// channel   dir  handshake           payload
// req       in   req_tvalid/tready   tdata: row_c0..row_c3, yaw/pitch/bend turns
// rsp       out  rsp_tvalid/tready   tdata: out_c0..out_c3, tuser: saturated
// csr       in   csr_wen             csr_index, csr_wdata
//
// one word per cycle in and out while the pipeline moves; the path runs through
// the cordic cell row, 22 transform steps and the output register
// the whole pipeline moves together; it stops only while a result sits
// unread in the output register
// reset is synchronous; it empties the pipeline and loads register defaults
`include "segment_local_transform_top_macros.svh"
module segment_local_transform_top import slt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // row_c0, row_c1, row_c2, row_c3, yaw_turn, pitch_turn, bend_turn
   input  wire logic [175:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_c0, out_c1, out_c2, out_c3
   output logic [127:0]      rsp_tdata,
   // saturated
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_wen,
   input  wire logic [2:0]   csr_index,
   input  wire logic [47:0]  csr_wdata
);

   cfg_type          cfg_ff;
   logic             advance;
   cell_type         chain_data [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0] chain_valid;
   logic [LANES-1:0][15:0] turns;
   trig_type         trig;
   logic [3:0][31:0] out_row;
   logic             out_sat;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.joint_enable <= 3'd7;
         cfg_ff.base_shift   <= '0;
         cfg_ff.pivot_shift  <= '0;
         cfg_ff.fixed_turn   <= '0;
         cfg_ff.fixed_axis   <= 48'h0100_0000_0000;
         cfg_ff.scale_xyz    <= 48'h0100_0100_0100;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_JOINT_ENABLE: cfg_ff.joint_enable <= csr_wdata[2:0];
            CSR_BASE_SHIFT:   cfg_ff.base_shift   <= csr_wdata;
            CSR_PIVOT_SHIFT:  cfg_ff.pivot_shift  <= csr_wdata;
            CSR_FIXED_TURN:   cfg_ff.fixed_turn   <= csr_wdata[15:0];
            CSR_FIXED_AXIS:   cfg_ff.fixed_axis   <= csr_wdata;
            CSR_SCALE_XYZ:    cfg_ff.scale_xyz    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // angle reduction to +-1/8 turn and cordic start values
   assign turns[0] = req_tdata[143:128];
   assign turns[1] = req_tdata[159:144];
   assign turns[2] = req_tdata[175:160];
   assign turns[3] = cfg_ff.fixed_turn;

   always_comb begin
      logic [16:0] biased;
      logic [31:0] resid;
      chain_data[0] = '0;
      for (int j = 0; j < 4; j++) begin
         chain_data[0].row[j] = req_tdata[32*j +: 32];
      end
      for (int l = 0; l < LANES; l++) begin
         biased = {1'b0, turns[l]} + 17'h2000;
         resid  = {turns[l], 16'h0000} - {biased[15:14], 30'd0};
         chain_data[0].quad[l] = biased[15:14];
         chain_data[0].x[l]    = XW'(GAIN_START);
         chain_data[0].y[l]    = '0;
         chain_data[0].z[l]    = ZW'($signed(resid));
      end
   end
   assign chain_valid[0] = req_tvalid;

   // cordic cell row
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      slt_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (SIW'(g)),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // quadrant fold back
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         unique case (chain_data[CORDIC_STAGES].quad[l])
            2'd0: begin
               trig.c[l] = chain_data[CORDIC_STAGES].x[l];
               trig.s[l] = chain_data[CORDIC_STAGES].y[l];
            end
            2'd1: begin
               trig.c[l] = -chain_data[CORDIC_STAGES].y[l];
               trig.s[l] = chain_data[CORDIC_STAGES].x[l];
            end
            2'd2: begin
               trig.c[l] = -chain_data[CORDIC_STAGES].x[l];
               trig.s[l] = -chain_data[CORDIC_STAGES].y[l];
            end
            default: begin
               trig.c[l] = chain_data[CORDIC_STAGES].y[l];
               trig.s[l] = -chain_data[CORDIC_STAGES].x[l];
            end
         endcase
      end
   end

   slt_row_path u_row (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_row    (chain_data[CORDIC_STAGES].row),
      .in_trig   (trig),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .out_row   (out_row),
      .out_sat   (out_sat)
   );

   assign rsp_tdata = out_row;
   assign rsp_tuser = out_sat;

   // checks
   `SLT_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_tvalid && !chain_valid[1])
   `SLT_ASSERT_NEXT(a_stall_freezes, clock, reset, !advance, $stable(chain_valid[CORDIC_STAGES:1]))
   `SLT_ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, chain_valid[1])
   `SLT_ASSERT_NEXT(a_stall_holds_out, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

endmodule
`default_nettype wire
